### rtl/core/repeated_balls_into_bins_round_defines.svh
// ----------------------------------------------------------------------------
// Repeated balls into bins round - assertion macros
// Concurrent assertion shorthands clocked on i_clk.
// ----------------------------------------------------------------------------
`ifndef REPEATED_BALLS_INTO_BINS_ROUND_DEFINES_SVH
`define REPEATED_BALLS_INTO_BINS_ROUND_DEFINES_SVH

// Property checked outside reset.
`define BIB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define BIB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### rtl/core/rbib_pkg.sv
// ----------------------------------------------------------------------------
// Repeated balls into bins round - package
// Sizes, function codes, request types and controller/datapath links.
// ----------------------------------------------------------------------------
`default_nettype none

package rbib_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int LOAD_BITS   = 16;
    localparam int BIN_BITS    = $clog2(TABLE_DEPTH);
    localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);
    localparam int FUNC_BITS   = 2;

    localparam logic [FUNC_BITS-1:0] FUNC_WRITE = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_START = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_PLACE = 2'd2;

    localparam logic [LOAD_BITS-1:0] LOAD_MAX = {LOAD_BITS{1'b1}};

    typedef struct packed {
        logic [FUNC_BITS-1:0] func;
        logic [BIN_BITS-1:0]  bin;
        logic [LOAD_BITS-1:0] load_value;
    } t_in_item;

    typedef struct packed {
        logic [LOAD_BITS-1:0] max_load;
        logic [CNT_BITS-1:0]  empty_bins;
        logic [CNT_BITS-1:0]  balls_remaining;
        logic                 round_done;
        logic                 rejected;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic                rd_en;
        logic [BIN_BITS-1:0] addr;
        logic                clr_wr;
        logic                latch;
        logic                rmw;
        logic                sweep_start;
        logic                sweep_step;
        logic                sweep_commit;
        logic                out_load;
        logic                reject;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic                pend_zero;
        logic [CNT_BITS-1:0] n_bins;
        logic                out_free;
    } t_status;

    // Force the bin count into 1..TABLE_DEPTH.
    function automatic logic [CNT_BITS-1:0] clamp_bins(input logic [CNT_BITS-1:0] v);
        logic [CNT_BITS-1:0] r;
        r = v;
        if (v == '0) begin
            r = CNT_BITS'(1);
        end else if (v > CNT_BITS'(TABLE_DEPTH)) begin
            r = CNT_BITS'(TABLE_DEPTH);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/rbib_ctrl.sv
// ----------------------------------------------------------------------------
// Repeated balls into bins round - controller
// Clear pass, request decode, read-modify-write and round sweep sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module rbib_ctrl
    import rbib_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_cfg_we,
    input  wire logic     i_in_valid,
    input  wire t_in_item i_in,
    output logic          o_in_stall,
    input  wire t_status  i_status,
    output t_cmd          o_cmd
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_RMW   = 2'd2;
    localparam logic [1:0] ST_SWEEP = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [CNT_BITS-1:0] r_addr, n_addr;
    logic                r_dv;

    logic accept;
    logic bin_ok;
    logic reject;

    assign o_in_stall = !((r_state == ST_IDLE) && i_status.out_free);
    assign accept     = i_in_valid && !o_in_stall;
    assign bin_ok     = {1'b0, i_in.bin} < i_status.n_bins;

    always_comb begin
        case (i_in.func)
            FUNC_WRITE: reject = !i_status.pend_zero || !bin_ok;
            FUNC_START: reject = !i_status.pend_zero;
            FUNC_PLACE: reject = i_status.pend_zero || !bin_ok;
            default:    reject = 1'b1;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                o_cmd.addr   = r_addr[BIN_BITS-1:0];
                n_addr       = r_addr + CNT_BITS'(1);
                if (r_addr == CNT_BITS'(TABLE_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (reject) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.reject   = 1'b1;
                    end else if (i_in.func == FUNC_START) begin
                        // issue the read of bin 0 now, sweep the rest
                        o_cmd.rd_en       = 1'b1;
                        o_cmd.addr        = '0;
                        o_cmd.sweep_start = 1'b1;
                        n_addr            = CNT_BITS'(1);
                        n_state           = ST_SWEEP;
                    end else begin
                        o_cmd.rd_en = 1'b1;
                        o_cmd.addr  = i_in.bin;
                        o_cmd.latch = 1'b1;
                        n_state     = ST_RMW;
                    end
                end
            end
            ST_RMW: begin
                o_cmd.rmw      = 1'b1;
                o_cmd.out_load = 1'b1;
                n_state        = ST_IDLE;
            end
            ST_SWEEP: begin
                o_cmd.sweep_step = r_dv;
                if (r_addr < i_status.n_bins) begin
                    o_cmd.rd_en = 1'b1;
                    o_cmd.addr  = r_addr[BIN_BITS-1:0];
                    n_addr      = r_addr + CNT_BITS'(1);
                end else if (r_dv) begin
                    // last bin comes back: commit the round
                    o_cmd.sweep_commit = 1'b1;
                    o_cmd.out_load     = 1'b1;
                    n_state            = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
                n_addr  = '0;
            end
        endcase
        // a register write restarts with a fresh clear pass
        if (i_cfg_we) begin
            n_state = ST_CLEAR;
            n_addr  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_addr  <= '0;
            r_dv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_dv    <= o_cmd.rd_en;
        end
    end

endmodule

`default_nettype wire

### rtl/core/rbib_dpath.sv
// ----------------------------------------------------------------------------
// Repeated balls into bins round - datapath
// Load table, round statistics, sweep accumulators and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rbib_dpath
    import rbib_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [CNT_BITS-1:0] i_cfg_data,
    input  wire t_in_item            i_in,
    input  wire t_cmd                i_cmd,
    output t_status                  o_status,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output t_out_item                o_out
);

    logic [LOAD_BITS-1:0] r_mem [TABLE_DEPTH];
    logic [LOAD_BITS-1:0] r_rd_data;
    logic [BIN_BITS-1:0]  r_rd_addr;

    logic [CNT_BITS-1:0]  r_n;
    logic [LOAD_BITS-1:0] r_max, n_max;
    logic [CNT_BITS-1:0]  r_empty, n_empty;
    logic [CNT_BITS-1:0]  r_pend, n_pend;

    logic                 r_is_write;
    logic [LOAD_BITS-1:0] r_value;

    logic [LOAD_BITS-1:0] r_acc_mx, acc_mx_nx;
    logic [CNT_BITS-1:0]  r_acc_emp, acc_emp_nx;
    logic [CNT_BITS-1:0]  r_acc_taken, acc_taken_nx;

    logic [LOAD_BITS-1:0] rmw_val;
    logic [LOAD_BITS-1:0] sweep_val;
    logic                 wr_en;
    logic [BIN_BITS-1:0]  wr_addr;
    logic [LOAD_BITS-1:0] wr_data;

    logic                 r_out_vld;
    t_out_item            r_out;

    assign o_status.pend_zero = (r_pend == '0);
    assign o_status.n_bins    = r_n;
    assign o_status.out_free  = !r_out_vld || !i_out_stall;
    assign o_out_valid        = r_out_vld;
    assign o_out              = r_out;

    // sweep: take one ball from a non-empty bin, fold into the running stats
    always_comb begin
        sweep_val    = (r_rd_data != '0) ? r_rd_data - LOAD_BITS'(1) : r_rd_data;
        acc_taken_nx = r_acc_taken + CNT_BITS'(r_rd_data != '0);
        acc_mx_nx    = (sweep_val > r_acc_mx) ? sweep_val : r_acc_mx;
        acc_emp_nx   = r_acc_emp + CNT_BITS'(sweep_val == '0);
    end

    always_comb begin
        rmw_val = r_rd_data;
        n_max   = r_max;
        n_empty = r_empty;
        n_pend  = r_pend;
        if (i_cmd.rmw) begin
            if (r_is_write) begin
                rmw_val = r_value;
                if (r_rd_data == '0 && r_value != '0) begin
                    n_empty = r_empty - CNT_BITS'(1);
                end else if (r_rd_data != '0 && r_value == '0) begin
                    n_empty = r_empty + CNT_BITS'(1);
                end
                if (r_value > r_max) begin
                    n_max = r_value;
                end
            end else begin
                // saturate; the ball still counts as placed
                if (r_rd_data != LOAD_MAX) begin
                    rmw_val = r_rd_data + LOAD_BITS'(1);
                    if (r_rd_data == '0 && r_empty != '0) begin
                        n_empty = r_empty - CNT_BITS'(1);
                    end
                end
                if (rmw_val > r_max) begin
                    n_max = rmw_val;
                end
                n_pend = r_pend - CNT_BITS'(1);
            end
        end
        if (i_cmd.sweep_commit) begin
            n_max   = acc_mx_nx;
            n_empty = acc_emp_nx;
            n_pend  = acc_taken_nx;
        end
    end

    always_comb begin
        wr_en   = i_cmd.clr_wr || i_cmd.rmw || i_cmd.sweep_step;
        wr_addr = i_cmd.clr_wr ? i_cmd.addr : r_rd_addr;
        if (i_cmd.clr_wr) begin
            wr_data = '0;
        end else if (i_cmd.rmw) begin
            wr_data = rmw_val;
        end else begin
            wr_data = sweep_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_cmd.addr];
            r_rd_addr <= i_cmd.addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n     <= CNT_BITS'(TABLE_DEPTH);
            r_max   <= '0;
            r_empty <= CNT_BITS'(TABLE_DEPTH);
            r_pend  <= '0;
        end else if (i_cfg_we) begin
            r_n     <= clamp_bins(i_cfg_data);
            r_max   <= '0;
            r_empty <= clamp_bins(i_cfg_data);
            r_pend  <= '0;
        end else begin
            r_max   <= n_max;
            r_empty <= n_empty;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_is_write <= (i_in.func == FUNC_WRITE);
            r_value    <= i_in.load_value[LOAD_BITS-1:0];
        end
        if (i_cmd.sweep_start) begin
            r_acc_mx    <= '0;
            r_acc_emp   <= '0;
            r_acc_taken <= '0;
        end else if (i_cmd.sweep_step) begin
            r_acc_mx    <= acc_mx_nx;
            r_acc_emp   <= acc_emp_nx;
            r_acc_taken <= acc_taken_nx;
        end
        if (i_cmd.out_load) begin
            r_out.max_load        <= n_max;
            r_out.empty_bins      <= n_empty;
            r_out.balls_remaining <= n_pend;
            r_out.round_done      <= (n_pend == '0);
            r_out.rejected        <= i_cmd.reject;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

endmodule

`default_nettype wire

### rtl/core/repeated_balls_into_bins_round.sv
// Flow: a write or placement request reads its bin when accepted, then writes it back and
// loads its result in ST_RMW; a rejected request loads its result straight from ST_IDLE; a
// round start sweeps the bins in use over the one read and one write port, one bin a cycle.
// Throughput: one request in flight; the next is taken once its result is out.
// Reset (synchronous, active low) and every bins_in_use write run a clear pass over all
// 1024 entries of the load table; requests are held off until it ends.
`default_nettype none

// ----------------------------------------------------------------------------
// Repeated balls into bins round - top level
// Joins the controller and the datapath and exposes the request channels.
// ----------------------------------------------------------------------------
module repeated_balls_into_bins_round
    import rbib_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [CNT_BITS-1:0] i_cfg_data,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire t_in_item            i_in,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output t_out_item                o_out
);

    t_cmd    cmd;
    t_status status;
    logic    cfg_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    rbib_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    rbib_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

### rtl/core/rbib_checker.sv
// ----------------------------------------------------------------------------
// Repeated balls into bins round - port checker
// Checks over time what the top level shows on its request ports.
// ----------------------------------------------------------------------------
`default_nettype none

`include "repeated_balls_into_bins_round_defines.svh"

module rbib_checker
    import rbib_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_in_stall,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_item o_out
);

    `BIB_ASSERT(a_done_matches_pending, o_out_valid |-> (o_out.round_done == (o_out.balls_remaining == '0)), "round_done disagrees with balls_remaining")

    `BIB_ASSERT(a_counts_in_range, o_out_valid |-> ((o_out.empty_bins <= CNT_BITS'(TABLE_DEPTH)) && (o_out.balls_remaining <= CNT_BITS'(TABLE_DEPTH))), "bin count out of range")

    `BIB_ASSERT(a_result_held, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out)), "stalled result dropped or changed")

    `BIB_ASSERT_ALWAYS(a_clear_after_reset, !i_rst_n |=> o_in_stall, "request taken during clear pass")

endmodule

bind repeated_balls_into_bins_round rbib_checker u_rbib_checker (.*);

`default_nettype wire
